[hdl/lmd_pkg.sv]
// Shared widths, register indexes, character codes and the Morse lookup table.
`timescale 1ns / 1ps

package lmd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int CHAR_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Widths of the widest symbol store the lookup function accepts.
    localparam int PAT_CNT_W  = 4;
    localparam int PAT_BITS_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_THRESHOLD = 2'd0,
        REG_DOT_LIMIT       = 2'd1,
        REG_LETTER_GAP      = 2'd2,
        REG_WORD_GAP        = 2'd3
    } cfg_index_t;

    // Indexed by a leading one above the pattern; a zero entry is unknown.
    localparam logic [7:0] CODE_TABLE [64] = '{
        8'd0, 8'd0,
        "E", "T",
        "I", "A", "N", "M",
        "S", "U", "R", "W", "D", "K", "G", "O",
        "H", "V", "F", 8'd0, "L", 8'd0, "P", "J",
        "B", "X", "C", "Y", "Z", "Q", 8'd0, 8'd0,
        "5", "4", 8'd0, "3", 8'd0, 8'd0, 8'd0, "2",
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "1",
        "6", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        "7", 8'd0, 8'd0, 8'd0, "8", 8'd0, "9", "0"
    };

    // Decodes the held symbols; the newest symbol sits in bit 0.
    function automatic logic [CHAR_W-1:0] decode_pattern(
        input logic [PAT_CNT_W-1:0]  count,
        input logic [PAT_BITS_W-1:0] bits
    );
        logic [5:0] idx;
        logic [7:0] c;
        idx = 6'd0;
        unique case (count)
            4'd1:    idx = {5'b00001, bits[0]};
            4'd2:    idx = {4'b0001, bits[1:0]};
            4'd3:    idx = {3'b001, bits[2:0]};
            4'd4:    idx = {2'b01, bits[3:0]};
            4'd5:    idx = {1'b1, bits[4:0]};
            default: idx = 6'd0;
        endcase
        c = CODE_TABLE[idx];
        return (c == 8'd0) ? CHAR_UNKNOWN : c[CHAR_W-1:0];
    endfunction

endpackage

[hdl/sample_if.sv]
// Input channel carrying one light sample and its timestamp per item.
`timescale 1ns / 1ps

interface sample_if import lmd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output sample_value, output time_ms, input ready);
    modport sink   (input valid, input sample_value, input time_ms, output ready);
endinterface

[hdl/char_if.sv]
// Output channel carrying one decoded character per item.
`timescale 1ns / 1ps

interface char_if import lmd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_run;

    modport source (output valid, output char_code, output last_of_run, input ready);
    modport sink   (input valid, input char_code, input last_of_run, output ready);
endinterface

[hdl/cfg_if.sv]
// Configuration write channel carrying a register index and write data.
`timescale 1ns / 1ps

interface cfg_if import lmd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/light_morse_decoder.sv]
// Top level of the light-sensor Morse decoder.
`timescale 1ns / 1ps

// The decoder takes one light sample per item and can accept a new item in
// every cycle while the result queue has room. An accepted item is held in
// an input register with its level resolved; once the queue has room, the
// level, the elapsed time since the last level change and the symbol store
// are evaluated and zero, one or two characters are written into a
// four-entry result queue, whose head drives the output channel, so a result
// is offered only after its sample has gone through both. The queue takes an
// item from the input register only when it has room for two characters, and
// the output port delivers one character per cycle while the receiver is
// ready, so the sustained rate is one item per cycle while items cause at most
// one character; when every item ends a word with a letter and a space, the
// queue fills and items are held back. Configuration writes are always
// accepted and should be made only while no item is in flight.
module light_morse_decoder import lmd_pkg::*; #(
    parameter int MAX_SYMBOLS = 5
) (
    input  logic     clk,
    input  logic     rst_n,
    sample_if.sink   samples,
    char_if.source   chars,
    cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_of_run;
    } result_t;

    // Configuration registers.
    logic [SAMPLE_W-1:0] light_threshold_reg;
    logic [LIMIT_W-1:0]  dot_limit_reg;
    logic [LIMIT_W-1:0]  letter_gap_reg;
    logic [LIMIT_W-1:0]  word_gap_reg;

    // Input register: the level is resolved at acceptance.
    logic              s1_valid_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_time_reg;

    // Decoder state.
    logic                   started_reg, started_next;
    logic                   prev_level_reg, prev_level_next;
    logic [TIME_W-1:0]      last_change_reg, last_change_next;
    logic [CNT_W-1:0]       symbol_count_reg, symbol_count_next;
    logic [MAX_SYMBOLS-1:0] symbol_bits_reg, symbol_bits_next;

    // Result queue.
    result_t              queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     q_count_reg;

    logic              s1_advance;
    logic [TIME_W-1:0] duration;
    logic              is_dash;
    logic              word_end;
    logic              letter_end;
    logic              pending;
    logic [CHAR_W-1:0] letter_char;
    logic [1:0]        n_write;
    result_t           entry0, entry1;
    logic              q_read;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_threshold_reg <= 12'd700;
            dot_limit_reg       <= 16'd150;
            letter_gap_reg      <= 16'd280;
            word_gap_reg        <= 16'd650;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_LIGHT_THRESHOLD: light_threshold_reg <= cfg.data[SAMPLE_W-1:0];
                REG_DOT_LIMIT:       dot_limit_reg       <= cfg.data;
                REG_LETTER_GAP:      letter_gap_reg      <= cfg.data;
                REG_WORD_GAP:        word_gap_reg        <= cfg.data;
            endcase
        end
    end

    // The input register moves on only when the queue can take a full pair.
    assign s1_advance    = s1_valid_reg && (q_count_reg <= (Q_PTR_W + 1)'(Q_DEPTH - 2));
    assign samples.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            s1_level_reg <= (samples.sample_value > light_threshold_reg);
            s1_time_reg  <= samples.time_ms;
        end
    end

    assign duration    = s1_time_reg - last_change_reg;
    assign is_dash     = !(duration < TIME_W'(dot_limit_reg));
    assign word_end    = duration > TIME_W'(word_gap_reg);
    assign letter_end  = duration > TIME_W'(letter_gap_reg);
    assign pending     = (symbol_count_reg != '0);
    assign letter_char = decode_pattern(PAT_CNT_W'(symbol_count_reg),
                                        PAT_BITS_W'(symbol_bits_reg));

    always_comb
    begin
        started_next      = started_reg;
        prev_level_next   = prev_level_reg;
        last_change_next  = last_change_reg;
        symbol_count_next = symbol_count_reg;
        symbol_bits_next  = symbol_bits_reg;
        n_write           = 2'd0;
        entry0            = '{char_code: CHAR_SPACE, last_of_run: 1'b1};
        entry1            = '{char_code: CHAR_SPACE, last_of_run: 1'b1};

        if (s1_advance)
        begin
            if (!started_reg)
            begin
                // The first sample only records the light level and its time.
                started_next     = 1'b1;
                prev_level_next  = s1_level_reg;
                last_change_next = s1_time_reg;
            end
            else if (s1_level_reg != prev_level_reg)
            begin
                prev_level_next  = s1_level_reg;
                last_change_next = s1_time_reg;
                if (!s1_level_reg)
                begin
                    // A mark has ended; a full store is cleared and the mark lost.
                    if (symbol_count_reg < CNT_W'(MAX_SYMBOLS))
                    begin
                        symbol_bits_next  = MAX_SYMBOLS'({symbol_bits_reg, is_dash});
                        symbol_count_next = symbol_count_reg + 1'b1;
                    end
                    else
                    begin
                        symbol_bits_next  = '0;
                        symbol_count_next = '0;
                    end
                end
                else if (word_end)
                begin
                    if (pending)
                    begin
                        entry0  = '{char_code: letter_char, last_of_run: 1'b0};
                        n_write = 2'd2;
                    end
                    else
                    begin
                        n_write = 2'd1;
                    end
                    symbol_bits_next  = '0;
                    symbol_count_next = '0;
                end
                else if (letter_end && pending)
                begin
                    entry0            = '{char_code: letter_char, last_of_run: 1'b1};
                    n_write           = 2'd1;
                    symbol_bits_next  = '0;
                    symbol_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            prev_level_reg   <= 1'b0;
            last_change_reg  <= '0;
            symbol_count_reg <= '0;
            symbol_bits_reg  <= '0;
        end
        else
        begin
            started_reg      <= started_next;
            prev_level_reg   <= prev_level_next;
            last_change_reg  <= last_change_next;
            symbol_count_reg <= symbol_count_next;
            symbol_bits_reg  <= symbol_bits_next;
        end
    end

    assign chars.valid       = (q_count_reg != '0);
    assign chars.char_code   = queue_reg[rd_ptr_reg].char_code;
    assign chars.last_of_run = queue_reg[rd_ptr_reg].last_of_run;
    assign q_read            = chars.valid && chars.ready;

    always_ff @(posedge clk)
    begin
        if (n_write != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= entry0;
        end
        if (n_write == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= entry1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_reg + Q_PTR_W'(n_write);
            if (q_read)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            q_count_reg <= q_count_reg + (Q_PTR_W + 1)'(n_write)
                           - (Q_PTR_W + 1)'(q_read);
        end
    end

endmodule

[hdl/lmd_checker.sv]
// Port-level assertions for the decoder and the bind that attaches them.
`timescale 1ns / 1ps

module lmd_checker import lmd_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] char_code,
    input logic              last_of_run
);

    // A space always closes the run of characters for its sample.
    a_space_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_code == CHAR_SPACE) |-> last_of_run)
        else $error("space delivered without last_of_run");

    // A letter that opens a pair is followed at once by its space.
    a_pair_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run
        && (char_code == CHAR_SPACE))
        else $error("letter of a pair not followed by its space");

    // A stalled item holds its value.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code)
        && $stable(last_of_run))
        else $error("output item changed while stalled");

endmodule

bind light_morse_decoder lmd_checker u_lmd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (chars.valid),
    .out_ready   (chars.ready),
    .char_code   (chars.char_code),
    .last_of_run (chars.last_of_run)
);
